/* rtl/aop_pkg.sv */
`default_nettype none

package aop_pkg;

    // field widths
    localparam int COORD_W = 32;
    localparam int PROD_W = 2 * COORD_W;
    localparam int DEPTH_W = 31;
    localparam int NRM_W = 2;

    // default number of fraction bits
    localparam int FRAC_BITS_DEF = 8;

    // front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // item kind
    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_TEST = 1'b1
    } t_action;

    // whole-unit normal codes, two bit signed
    localparam logic [NRM_W-1:0] NRM_ZERO = 2'b00;
    localparam logic [NRM_W-1:0] NRM_POS = 2'b01;
    localparam logic [NRM_W-1:0] NRM_NEG = 2'b11;

    // adjusted box as it travels through the queue
    typedef struct packed {
        t_action                    action;
        logic signed [COORD_W-1:0]  min_x;
        logic signed [COORD_W-1:0]  max_x;
        logic signed [COORD_W-1:0]  min_y;
        logic signed [COORD_W-1:0]  max_y;
    } t_box;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* rtl/aop_front.sv */
`default_nettype none

module aop_front #(
    parameter int FRAC_BITS = aop_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_action,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_pos_x,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_pos_y,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_scale_x,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_scale_y,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_min_x,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_min_y,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_max_x,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_max_y,
    input  wire aop_pkg::t_q_stat                   i_q_stat,
    output logic                                    o_push,
    output aop_pkg::t_box                           o_push_box
);

    localparam int CW = aop_pkg::COORD_W;
    localparam int PW = aop_pkg::PROD_W;

    logic                   r_f1_valid;
    logic                   n_f1_valid;
    aop_pkg::t_action       r_action;
    logic signed [CW-1:0]   r_pos_x;
    logic signed [CW-1:0]   r_pos_y;
    logic signed [PW-1:0]   r_prod_min_x;
    logic signed [PW-1:0]   r_prod_max_x;
    logic signed [PW-1:0]   r_prod_min_y;
    logic signed [PW-1:0]   r_prod_max_y;
    logic                   f_en;
    logic signed [CW-1:0]   sc_min_x;
    logic signed [CW-1:0]   sc_max_x;
    logic signed [CW-1:0]   sc_min_y;
    logic signed [CW-1:0]   sc_max_y;
    logic signed [CW-1:0]   lo_x;
    logic signed [CW-1:0]   hi_x;
    logic signed [CW-1:0]   lo_y;
    logic signed [CW-1:0]   hi_y;

    // front holds while its product stage cannot drain into the queue
    assign f_en = !(r_f1_valid && i_q_stat.full);
    assign o_in_stall = !f_en;
    assign n_f1_valid = f_en ? i_in_valid : r_f1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= n_f1_valid;
        end
    end

    // corner times scale, full 64-bit products
    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_action <= aop_pkg::t_action'(i_action);
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_prod_min_x <= PW'(i_min_x) * PW'(i_scale_x);
            r_prod_max_x <= PW'(i_max_x) * PW'(i_scale_x);
            r_prod_min_y <= PW'(i_min_y) * PW'(i_scale_y);
            r_prod_max_y <= PW'(i_max_y) * PW'(i_scale_y);
        end
    end

    // floor shift by the fraction bits, keep low 32 bits
    assign sc_min_x = r_prod_min_x[FRAC_BITS +: CW];
    assign sc_max_x = r_prod_max_x[FRAC_BITS +: CW];
    assign sc_min_y = r_prod_min_y[FRAC_BITS +: CW];
    assign sc_max_y = r_prod_max_y[FRAC_BITS +: CW];

    // reorder corners
    assign lo_x = (sc_min_x < sc_max_x) ? sc_min_x : sc_max_x;
    assign hi_x = (sc_min_x < sc_max_x) ? sc_max_x : sc_min_x;
    assign lo_y = (sc_min_y < sc_max_y) ? sc_min_y : sc_max_y;
    assign hi_y = (sc_min_y < sc_max_y) ? sc_max_y : sc_min_y;

    // translate with wrap and hand to the queue
    assign o_push = r_f1_valid && !i_q_stat.full;
    assign o_push_box.action = r_action;
    assign o_push_box.min_x = lo_x + r_pos_x;
    assign o_push_box.max_x = hi_x + r_pos_x;
    assign o_push_box.min_y = lo_y + r_pos_y;
    assign o_push_box.max_y = hi_y + r_pos_y;

endmodule

`default_nettype wire

/* rtl/aop_queue.sv */
`default_nettype none

module aop_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire aop_pkg::t_box    i_push_box,
    input  wire logic             i_pop,
    output aop_pkg::t_box         o_head_box,
    output aop_pkg::t_q_stat      o_q_stat
);

    localparam int PTR_W = aop_pkg::QPTR_W;
    localparam int CNT_W = aop_pkg::QCNT_W;
    localparam int DEPTH = aop_pkg::QUEUE_DEPTH;

    aop_pkg::t_box      r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_q_stat.full = (r_count == CNT_W'(DEPTH));
    assign o_q_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_q_stat.full;
    assign do_pop = i_pop && !o_q_stat.empty;
    assign o_head_box = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_box;
        end
    end

endmodule

`default_nettype wire

/* rtl/aop_back.sv */
`default_nettype none

module aop_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire aop_pkg::t_box                  i_head_box,
    input  wire aop_pkg::t_q_stat               i_q_stat,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_hit,
    output logic [aop_pkg::DEPTH_W-1:0]         o_depth,
    output logic signed [aop_pkg::NRM_W-1:0]    o_normal_x,
    output logic signed [aop_pkg::NRM_W-1:0]    o_normal_y
);

    localparam int CW = aop_pkg::COORD_W;
    localparam int EW = CW + 1;     // extent and center
    localparam int DW = CW + 2;     // center difference
    localparam int PW = CW + 3;     // overlap
    localparam int OW = aop_pkg::DEPTH_W;
    localparam int NW = aop_pkg::NRM_W;

    // stored box a
    logic signed [CW-1:0]   r_a_min_x;
    logic signed [CW-1:0]   r_a_max_x;
    logic signed [CW-1:0]   r_a_min_y;
    logic signed [CW-1:0]   r_a_max_y;

    // stage 1: extents and hit
    logic                   r_b1_valid;
    logic                   r_b1_hit;
    logic signed [EW-1:0]   r_b1_ex_ax;
    logic signed [EW-1:0]   r_b1_ex_bx;
    logic signed [EW-1:0]   r_b1_ex_ay;
    logic signed [EW-1:0]   r_b1_ex_by;
    logic signed [CW-1:0]   r_b1_amin_x;
    logic signed [CW-1:0]   r_b1_bmin_x;
    logic signed [CW-1:0]   r_b1_amin_y;
    logic signed [CW-1:0]   r_b1_bmin_y;

    // stage 2: centers and half sums
    logic                   r_b2_valid;
    logic                   r_b2_hit;
    logic signed [EW-1:0]   r_b2_ca_x;
    logic signed [EW-1:0]   r_b2_cb_x;
    logic signed [EW-1:0]   r_b2_ca_y;
    logic signed [EW-1:0]   r_b2_cb_y;
    logic signed [EW-1:0]   r_b2_hs_x;
    logic signed [EW-1:0]   r_b2_hs_y;

    // stage 3: center differences
    logic                   r_b3_valid;
    logic                   r_b3_hit;
    logic signed [DW-1:0]   r_b3_d_x;
    logic signed [DW-1:0]   r_b3_d_y;
    logic signed [EW-1:0]   r_b3_hs_x;
    logic signed [EW-1:0]   r_b3_hs_y;

    // stage 4: overlaps
    logic                   r_b4_valid;
    logic                   r_b4_hit;
    logic signed [PW-1:0]   r_b4_p_x;
    logic signed [PW-1:0]   r_b4_p_y;
    logic [NW-1:0]          r_b4_n_x;
    logic [NW-1:0]          r_b4_n_y;

    // stage 5: chosen axis
    logic                   r_b5_valid;
    logic                   r_b5_hit;
    logic signed [PW-1:0]   r_b5_p;
    logic [NW-1:0]          r_b5_n_x;
    logic [NW-1:0]          r_b5_n_y;

    // result register
    logic                   r_out_valid;
    logic                   r_hit;
    logic [OW-1:0]          r_depth;
    logic [NW-1:0]          r_normal_x;
    logic [NW-1:0]          r_normal_y;

    logic                   b_en;
    logic                   is_load;
    logic                   n_b1_valid;
    logic                   hit_now;
    logic signed [EW-1:0]   ha_x;
    logic signed [EW-1:0]   hb_x;
    logic signed [EW-1:0]   ha_y;
    logic signed [EW-1:0]   hb_y;
    logic signed [PW-1:0]   p_x;
    logic signed [PW-1:0]   p_y;
    logic [PW-1:0]          mag;

    // negated sign of a center difference as a normal code
    function automatic logic [NW-1:0] neg_sign(input logic signed [DW-1:0] d);
        logic [NW-1:0] code;
        if (d > 0) begin
            code = aop_pkg::NRM_NEG;
        end else if (d < 0) begin
            code = aop_pkg::NRM_POS;
        end else begin
            code = aop_pkg::NRM_ZERO;
        end
        return code;
    endfunction

    // whole back pipeline moves unless the result register is held
    assign b_en = !(r_out_valid && i_out_stall);
    assign o_pop = b_en && !i_q_stat.empty;
    assign is_load = (i_head_box.action == aop_pkg::ACT_LOAD);
    assign n_b1_valid = o_pop && !is_load;

    assign hit_now = (r_a_min_x <= i_head_box.max_x) && (r_a_max_x >= i_head_box.min_x) &&
                     (r_a_min_y <= i_head_box.max_y) && (r_a_max_y >= i_head_box.min_y);

    // box a update on a load item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_min_x <= '0;
            r_a_max_x <= '0;
            r_a_min_y <= '0;
            r_a_max_y <= '0;
        end else if (o_pop && is_load) begin
            r_a_min_x <= i_head_box.min_x;
            r_a_max_x <= i_head_box.max_x;
            r_a_min_y <= i_head_box.min_y;
            r_a_max_y <= i_head_box.max_y;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_b4_valid <= 1'b0;
            r_b5_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_b1_valid <= n_b1_valid;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
            r_b4_valid <= r_b3_valid;
            r_b5_valid <= r_b4_valid;
            r_out_valid <= r_b5_valid;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b1_hit <= hit_now;
            r_b1_ex_ax <= EW'(r_a_max_x) - EW'(r_a_min_x);
            r_b1_ex_bx <= EW'(i_head_box.max_x) - EW'(i_head_box.min_x);
            r_b1_ex_ay <= EW'(r_a_max_y) - EW'(r_a_min_y);
            r_b1_ex_by <= EW'(i_head_box.max_y) - EW'(i_head_box.min_y);
            r_b1_amin_x <= r_a_min_x;
            r_b1_bmin_x <= i_head_box.min_x;
            r_b1_amin_y <= r_a_min_y;
            r_b1_bmin_y <= i_head_box.min_y;
        end
    end

    // floor halves of the extents
    assign ha_x = r_b1_ex_ax >>> 1;
    assign hb_x = r_b1_ex_bx >>> 1;
    assign ha_y = r_b1_ex_ay >>> 1;
    assign hb_y = r_b1_ex_by >>> 1;

    // stage 2
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b2_hit <= r_b1_hit;
            r_b2_ca_x <= EW'(r_b1_amin_x) + ha_x;
            r_b2_cb_x <= EW'(r_b1_bmin_x) + hb_x;
            r_b2_ca_y <= EW'(r_b1_amin_y) + ha_y;
            r_b2_cb_y <= EW'(r_b1_bmin_y) + hb_y;
            r_b2_hs_x <= ha_x + hb_x;
            r_b2_hs_y <= ha_y + hb_y;
        end
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b3_hit <= r_b2_hit;
            r_b3_d_x <= DW'(r_b2_cb_x) - DW'(r_b2_ca_x);
            r_b3_d_y <= DW'(r_b2_cb_y) - DW'(r_b2_ca_y);
            r_b3_hs_x <= r_b2_hs_x;
            r_b3_hs_y <= r_b2_hs_y;
        end
    end

    // half sum minus absolute center difference
    assign p_x = (r_b3_d_x < 0) ? PW'(r_b3_hs_x) + PW'(r_b3_d_x)
                                : PW'(r_b3_hs_x) - PW'(r_b3_d_x);
    assign p_y = (r_b3_d_y < 0) ? PW'(r_b3_hs_y) + PW'(r_b3_d_y)
                                : PW'(r_b3_hs_y) - PW'(r_b3_d_y);

    // stage 4
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b4_hit <= r_b3_hit;
            r_b4_p_x <= p_x;
            r_b4_p_y <= p_y;
            r_b4_n_x <= neg_sign(r_b3_d_x);
            r_b4_n_y <= neg_sign(r_b3_d_y);
        end
    end

    // stage 5: smaller overlap axis, tie to y
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b5_hit <= r_b4_hit;
            if (r_b4_p_x < r_b4_p_y) begin
                r_b5_p <= r_b4_p_x;
                r_b5_n_x <= r_b4_n_x;
                r_b5_n_y <= aop_pkg::NRM_ZERO;
            end else begin
                r_b5_p <= r_b4_p_y;
                r_b5_n_x <= aop_pkg::NRM_ZERO;
                r_b5_n_y <= r_b4_n_y;
            end
        end
    end

    // magnitude, then saturate into the depth field
    assign mag = (r_b5_p < 0) ? PW'(-r_b5_p) : PW'(r_b5_p);

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_hit <= r_b5_hit;
            if (!r_b5_hit) begin
                r_depth <= '0;
                r_normal_x <= aop_pkg::NRM_ZERO;
                r_normal_y <= aop_pkg::NRM_ZERO;
            end else begin
                r_depth <= (mag > PW'({OW{1'b1}})) ? {OW{1'b1}} : mag[OW-1:0];
                r_normal_x <= r_b5_n_x;
                r_normal_y <= r_b5_n_y;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit = r_hit;
    assign o_depth = r_depth;
    assign o_normal_x = r_normal_x;
    assign o_normal_y = r_normal_y;

endmodule

`default_nettype wire

/* rtl/aabb_overlap_penetration_core.sv */
`default_nettype none

// channel   valid        stall        payload
// input     i_in_valid   o_in_stall   i_action, i_pos_*, i_scale_*, i_min_*, i_max_*
// output    o_out_valid  i_out_stall  o_hit, o_depth, o_normal_x, o_normal_y
//
// one item per cycle sustained while nothing stalls; a test result passes
// through one product stage, the queue, five back stages and the result
// register. load items give no result.
// reset is synchronous and active low; it clears box a to zero.
// the front stalls only when its product stage is held by a full queue.
// an output stall freezes the back; the four-entry queue absorbs the front.

module aabb_overlap_penetration_core #(
    parameter int FRAC_BITS = aop_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_action,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_pos_x,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_pos_y,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_scale_x,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_scale_y,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_min_x,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_min_y,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_max_x,
    input  wire logic signed [aop_pkg::COORD_W-1:0] i_max_y,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_hit,
    output logic [aop_pkg::DEPTH_W-1:0]             o_depth,
    output logic signed [aop_pkg::NRM_W-1:0]        o_normal_x,
    output logic signed [aop_pkg::NRM_W-1:0]        o_normal_y
);

    logic               w_push;
    aop_pkg::t_box      w_push_box;
    logic               w_pop;
    aop_pkg::t_box      w_head_box;
    aop_pkg::t_q_stat   w_q_stat;

    // scale, reorder and translate
    aop_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_action   (i_action),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_scale_x  (i_scale_x),
        .i_scale_y  (i_scale_y),
        .i_min_x    (i_min_x),
        .i_min_y    (i_min_y),
        .i_max_x    (i_max_x),
        .i_max_y    (i_max_y),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_push_box (w_push_box)
    );

    // adjusted boxes between front and back
    aop_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_box (w_push_box),
        .i_pop      (w_pop),
        .o_head_box (w_head_box),
        .o_q_stat   (w_q_stat)
    );

    // box a store, overlap test and depth
    aop_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_box  (w_head_box),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_depth     (o_depth),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y)
    );

    // a miss carries no depth and no normal
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |->
            o_depth == '0 && o_normal_x == aop_pkg::NRM_ZERO &&
            o_normal_y == aop_pkg::NRM_ZERO)
        else $error("miss result with nonzero depth or normal");

    // the normal lies on one axis only
    a_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_normal_x == aop_pkg::NRM_ZERO || o_normal_y == aop_pkg::NRM_ZERO)
        else $error("normal set on both axes");

    // the normal is a whole unit
    a_unit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_normal_x != 2'b10 && o_normal_y != 2'b10)
        else $error("normal code out of range");

    // queue cannot be full and empty at once, and stalls only when full
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty) && (!o_in_stall || w_q_stat.full))
        else $error("queue status inconsistent");

endmodule

`default_nettype wire
